>>> src/md5_pkg.sv
package md5_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_CSTART,
        S_CA,
        S_CB,
        S_CFOLD,
        S_OUT
    } md5_state_t;

    typedef struct packed {
        logic       load_work;
        logic       phase_a;
        logic       phase_b;
        logic       fold;
        logic       init_chain;
        logic [5:0] step;
        logic [1:0] out_idx;
    } md5_ctl_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_STEP = 6'd63;
    localparam logic [1:0] LAST_IDX = 2'd3;

    localparam logic [31:0] MD5_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    function automatic logic [3:0] md5_msg_index(input logic [5:0] step);
        logic [3:0] i;
        logic [3:0] g;
        i = step[3:0];
        case (step[5:4])
            2'd0:    g = i;
            2'd1:    g = (i << 2) + i + 4'd1;
            2'd2:    g = (i << 1) + i + 4'd5;
            default: g = (i << 2) + (i << 1) + i;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [1:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (rnd)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] w;
        w = {x, x} << s;
        return w[63:32];
    endfunction

endpackage

>>> src/md5_ram.sv
module md5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/md5_round.sv
module md5_round import md5_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  md5_ctl_t    ctl,
    input  logic [31:0] msg_word,
    output logic [31:0] digest_word
);

    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, t_reg;
    logic [31:0] t_next;
    logic [31:0] b_next;
    logic [3:0]  rot_sel;

    assign t_next  = a_reg + md5_f(ctl.step[5:4], b_reg, c_reg, d_reg) + msg_word
                   + MD5_K[ctl.step];
    assign rot_sel = {ctl.step[5:4], ctl.step[1:0]};
    assign b_next  = b_reg + md5_rotl(t_reg, MD5_S[rot_sel]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) chain_reg[k] <= MD5_IV[k];
        end else if (ctl.init_chain) begin
            for (int k = 0; k < 4; k++) chain_reg[k] <= MD5_IV[k];
        end else if (ctl.fold) begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_work) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end else if (ctl.phase_b) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_next;
        end
        if (ctl.phase_a) begin
            t_reg <= t_next;
        end
    end

    assign digest_word = chain_reg[ctl.out_idx];

endmodule

>>> src/md5_ctrl.sv
module md5_ctrl import md5_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_byte_valid,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_word_index,
    output logic       m_last_word,
    output md5_ctl_t   ctl,
    output logic       ram_we,
    output logic [5:0] ram_waddr,
    output logic [7:0] ram_wdata,
    output logic [3:0] ram_raddr
);

    md5_state_t  state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [63:0] bit_total_reg, bit_total_next;
    logic [5:0]  pad_pos_reg, pad_pos_next;
    logic        mark_reg, mark_next;
    logic        lenblk_reg, lenblk_next;
    logic        pad_more_reg, pad_more_next;
    logic        out_pend_reg, out_pend_next;
    logic [1:0]  out_idx_reg, out_idx_next;

    logic [5:0]  pos;
    logic [5:0]  start_pos;
    logic        accept;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;
    logic [5:0]  rd_step;

    assign pos       = bit_total_reg[8:3];
    assign start_pos = s_byte_valid ? pos + 6'd1 : pos;
    assign accept    = s_valid && s_ready;
    assign len_byte  = bit_total_reg[{pad_pos_reg[2:0], 3'b000} +: 8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            bit_total_reg <= '0;
            pad_pos_reg   <= '0;
            mark_reg      <= 1'b0;
            lenblk_reg    <= 1'b0;
            pad_more_reg  <= 1'b0;
            out_pend_reg  <= 1'b0;
            out_idx_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            bit_total_reg <= bit_total_next;
            pad_pos_reg   <= pad_pos_next;
            mark_reg      <= mark_next;
            lenblk_reg    <= lenblk_next;
            pad_more_reg  <= pad_more_next;
            out_pend_reg  <= out_pend_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        bit_total_next = bit_total_reg;
        pad_pos_next   = pad_pos_reg;
        mark_next      = mark_reg;
        lenblk_next    = lenblk_reg;
        pad_more_next  = pad_more_reg;
        out_pend_next  = out_pend_reg;
        out_idx_next   = out_idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_byte_valid) begin
                        bit_total_next = bit_total_reg + 64'd8;
                    end
                    if (s_byte_valid && pos == LAST_POS) begin
                        state_next    = S_CSTART;
                        pad_more_next = s_end_of_message;
                        out_pend_next = 1'b0;
                        mark_next     = 1'b1;
                        lenblk_next   = 1'b1;
                        pad_pos_next  = '0;
                    end else if (s_end_of_message) begin
                        state_next    = S_PAD;
                        pad_pos_next  = start_pos;
                        mark_next     = 1'b1;
                        lenblk_next   = start_pos < LEN_POS;
                    end
                end
            end
            S_PAD: begin
                mark_next    = 1'b0;
                pad_pos_next = pad_pos_reg + 6'd1;
                if (pad_pos_reg == LAST_POS) begin
                    lenblk_next   = 1'b1;
                    pad_more_next = !lenblk_reg;
                    out_pend_next = lenblk_reg;
                    state_next    = S_CSTART;
                end
            end
            S_CSTART: begin
                step_next  = '0;
                state_next = S_CA;
            end
            S_CA: begin
                state_next = S_CB;
            end
            S_CB: begin
                step_next  = step_reg + 6'd1;
                state_next = (step_reg == LAST_STEP) ? S_CFOLD : S_CA;
            end
            S_CFOLD: begin
                if (out_pend_reg) begin
                    state_next   = S_OUT;
                    out_idx_next = '0;
                end else if (pad_more_reg) begin
                    state_next    = S_PAD;
                    pad_more_next = 1'b0;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 2'd1;
                    if (out_idx_reg == LAST_IDX) begin
                        state_next     = S_IDLE;
                        out_pend_next  = 1'b0;
                        bit_total_next = '0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = state_reg == S_IDLE;
        m_valid        = state_reg == S_OUT;
        m_word_index   = out_idx_reg;
        m_last_word    = out_idx_reg == LAST_IDX;
        ctl.load_work  = state_reg == S_CSTART;
        ctl.phase_a    = state_reg == S_CA;
        ctl.phase_b    = state_reg == S_CB;
        ctl.fold       = state_reg == S_CFOLD;
        ctl.init_chain = state_reg == S_OUT && m_ready && out_idx_reg == LAST_IDX;
        ctl.step       = step_reg;
        ctl.out_idx    = out_idx_reg;
        if (mark_reg) begin
            pad_byte = PAD_MARK;
        end else if (lenblk_reg && pad_pos_reg >= LEN_POS) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = '0;
        end
        ram_we    = (state_reg == S_IDLE && accept && s_byte_valid) || state_reg == S_PAD;
        ram_waddr = (state_reg == S_IDLE) ? pos : pad_pos_reg;
        ram_wdata = (state_reg == S_IDLE) ? s_data_byte : pad_byte;
        rd_step   = (state_reg == S_CB) ? step_reg + 6'd1 : 6'd0;
        ram_raddr = md5_msg_index(rd_step);
    end

    a_ready_out_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels active together");

    a_last_step_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CB && step_reg == LAST_STEP) |=> state_reg == S_CFOLD)
        else $error("compression did not fold after the last step");

    a_pend_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_pend_reg && pad_more_reg))
        else $error("digest pending while padding still owed");

    a_last_beat_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (s_ready && bit_total_reg == '0))
        else $error("block not reinitialized after final digest beat");

endmodule

>>> src/md5_message_digest_top.sv
// MD5 digest engine, fed one message byte per input beat.
// Input channel (s_*): each beat carries data_byte with byte_valid, and
// end_of_message to close the message; a beat with neither flag is a no-op.
// Result channel (m_*): after a closing beat the block sends four beats,
// digest words A..D (word_index 0..3), last_word set on word D, then
// reinitializes for the next message.
// Flow: s_ready stays high while bytes that do not fill a block come in. A
// byte that completes a 64-byte block starts a compression: one shared round
// unit runs the 64 steps, each an add and then a rotate and add, with a load
// state before them and a fold state after. A closing beat takes the padding
// writes (one byte a cycle to the end of each padded block), one or two
// compressions and then the four result beats; s_ready is low throughout.
// Message bytes sit in four 16x8 byte-lane RAMs, read one word per step.
// Reset (aresetn low, synchronous) restores the initial chaining words and
// clears the bit count. When the receiver stalls, the current digest word
// holds on m_* and no input is taken until all four beats are delivered.
module md5_message_digest_top import md5_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [1:0]  m_word_index,
    output logic        m_last_word
);

    md5_ctl_t    ctl;
    logic        ram_we;
    logic [5:0]  ram_waddr;
    logic [7:0]  ram_wdata;
    logic [3:0]  ram_raddr;
    logic [31:0] msg_word;

    md5_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_byte_valid     (s_byte_valid),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_word_index     (m_word_index),
        .m_last_word      (m_last_word),
        .ctl              (ctl),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_raddr        (ram_raddr)
    );

    for (genvar k = 0; k < 4; k++) begin : g_lane
        md5_ram #(
            .WIDTH (8),
            .DEPTH (16)
        ) u_lane (
            .clk   (aclk),
            .we    (ram_we && ram_waddr[1:0] == 2'(k)),
            .waddr (ram_waddr[5:2]),
            .wdata (ram_wdata),
            .raddr (ram_raddr),
            .rdata (msg_word[8*k +: 8])
        );
    end

    md5_round u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .msg_word    (msg_word),
        .digest_word (m_digest_word)
    );

endmodule
